// File: sv/t5css_pkg.sv
// shared constants for the top-five class score selector
// field widths, q1.14 unity and parameter defaults; no dependencies
`default_nettype none

package t5css_pkg;

	localparam int SCORE_W = 16;
	localparam int CLASS_W = 10;
	localparam int RANK_W  = 3;

	// 1.0 in signed q1.14
	localparam logic signed [SCORE_W-1:0] Q_ONE = 16'sd16384;
	localparam logic signed [SCORE_W-1:0] Q_ZERO = 16'sd0;

	localparam int MAX_CLASSES_DEF = 1024;
	localparam int TOP_COUNT_DEF   = 5;

endpackage

`default_nettype wire

// File: sv/top5_class_score_select_top.sv
// top-five class score selector, top level
// depends on t5css_pkg for field widths, q1.14 constants and parameter defaults
`default_nettype none

// Takes one classifier score per item, in class order, and keeps a descending list
// of the TOP_COUNT best scores with their class numbers (the list starts as all zero
// scores of class 0, so only positive scores can enter). A score enters above the
// first kept score it strictly exceeds; equal scores do not pass, so the earlier
// class keeps the higher place. The item flagged final_score is itself ranked, then
// the whole list goes out as TOP_COUNT result items, best first, rank 0 upwards,
// and the list and class counter start again from zero. probabilities_valid is the
// same on all results of a run: 1 when every kept score lies in 0.0..1.0 inclusive.
// Classes from MAX_CLASSES onwards are ignored; class_index is the low ten bits of
// the class number and rank the low three bits of the list position.
// Timing: an item is registered on entry and ranked in the following cycle, so one
// score item is taken every cycle when not stalled. A final item copies the list
// into a result bank in that cycle; the bank drains one result per cycle when
// out_stall is low, TOP_COUNT results per run. A second final item waits in the
// input register until the bank has sent its last result; only this raises in_stall.
module top5_class_score_select_top #(
	parameter int MAX_CLASSES = t5css_pkg::MAX_CLASSES_DEF,
	parameter int TOP_COUNT   = t5css_pkg::TOP_COUNT_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// score input channel
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [t5css_pkg::SCORE_W-1:0]   score,
	input  wire logic                                   final_score,
	// ranked result channel
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic [t5css_pkg::RANK_W-1:0]                rank,
	output logic [t5css_pkg::CLASS_W-1:0]               class_index,
	output logic signed [t5css_pkg::SCORE_W-1:0]        ranked_score,
	output logic                                        probabilities_valid,
	output logic                                        last_of_run
);

	localparam int SW    = t5css_pkg::SCORE_W;
	localparam int CW    = t5css_pkg::CLASS_W;
	localparam int RW    = t5css_pkg::RANK_W;
	// counter holds up to MAX_CLASSES itself
	localparam int CNT_W = $clog2(MAX_CLASSES + 1);
	localparam int IDX_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

	// input register
	logic                 valid_s1;
	logic signed [SW-1:0] score_s1;
	logic                 final_s1;

	// live list and class counter
	logic signed [SW-1:0] top_score_q [TOP_COUNT];
	logic [CW-1:0]        top_class_q [TOP_COUNT];
	logic [CNT_W-1:0]     cnt_q;

	// result bank
	logic signed [SW-1:0] bank_score_q [TOP_COUNT];
	logic [CW-1:0]        bank_class_q [TOP_COUNT];
	logic                 prob_ok_q;
	logic                 out_valid_q;
	logic [IDX_W-1:0]     rd_q;

	// ranking logic
	logic                 take_s1;
	logic [CNT_W+CW-1:0]  cnt_ext;
	logic [CW-1:0]        cur_class;
	logic signed [SW-1:0] nxt_score [TOP_COUNT];
	logic [CW-1:0]        nxt_class [TOP_COUNT];
	logic                 found;
	logic                 found_prev;
	logic signed [SW-1:0] prev_score;
	logic [CW-1:0]        prev_class;
	logic                 prob_ok;
	logic                 list_ordered;

	// handshake
	logic                 out_accept;
	logic                 bank_last;
	logic                 bank_free;
	logic                 adv_s1;
	logic                 fire_s1;
	logic                 load_bank;
	logic [IDX_W+RW-1:0]  rank_ext;

	// control
	assign out_accept = out_valid_q && !out_stall;
	assign bank_last  = (rd_q == IDX_W'(TOP_COUNT - 1));
	assign bank_free  = !out_valid_q || (out_accept && bank_last);
	// only a final item has to wait for the bank
	assign adv_s1     = !final_s1 || bank_free;
	assign in_stall   = valid_s1 && !adv_s1;
	assign fire_s1    = valid_s1 && adv_s1;
	assign load_bank  = fire_s1 && final_s1;

	// classes past the limit are dropped
	assign take_s1   = (cnt_q < CNT_W'(MAX_CLASSES));
	assign cnt_ext   = {{CW{1'b0}}, cnt_q};
	assign cur_class = cnt_ext[CW-1:0];

	// insertion: entries from the first strictly smaller one down shift by one
	always_comb begin
		found      = 1'b0;
		found_prev = 1'b0;
		prev_score = t5css_pkg::Q_ZERO;
		prev_class = '0;
		for (int k = 0; k < TOP_COUNT; k++) begin
			found_prev = found;
			found      = found || (take_s1 && (score_s1 > top_score_q[k]));
			if (found && !found_prev) begin
				nxt_score[k] = score_s1;
				nxt_class[k] = cur_class;
			end else if (found_prev) begin
				nxt_score[k] = prev_score;
				nxt_class[k] = prev_class;
			end else begin
				nxt_score[k] = top_score_q[k];
				nxt_class[k] = top_class_q[k];
			end
			prev_score = top_score_q[k];
			prev_class = top_class_q[k];
		end
	end

	// every kept score within 0.0 .. 1.0
	always_comb begin
		prob_ok = 1'b1;
		for (int k = 0; k < TOP_COUNT; k++) begin
			if (nxt_score[k] < t5css_pkg::Q_ZERO || nxt_score[k] > t5css_pkg::Q_ONE) begin
				prob_ok = 1'b0;
			end
		end
	end

	// input register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// input register: payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			score_s1 <= score;
			final_s1 <= final_score;
		end
	end

	// live list, cleared after each run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int k = 0; k < TOP_COUNT; k++) begin
				top_score_q[k] <= t5css_pkg::Q_ZERO;
				top_class_q[k] <= '0;
			end
		end else if (fire_s1) begin
			if (final_s1) begin
				cnt_q <= '0;
				for (int k = 0; k < TOP_COUNT; k++) begin
					top_score_q[k] <= t5css_pkg::Q_ZERO;
					top_class_q[k] <= '0;
				end
			end else begin
				if (take_s1) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				for (int k = 0; k < TOP_COUNT; k++) begin
					top_score_q[k] <= nxt_score[k];
					top_class_q[k] <= nxt_class[k];
				end
			end
		end
	end

	// result bank: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rd_q        <= '0;
		end else if (load_bank) begin
			out_valid_q <= 1'b1;
			rd_q        <= '0;
		end else if (out_accept) begin
			if (bank_last) begin
				out_valid_q <= 1'b0;
				rd_q        <= '0;
			end else begin
				rd_q <= rd_q + IDX_W'(1);
			end
		end
	end

	// result bank: payload, snapshot of the list including the final score
	always_ff @(posedge clk) begin
		if (load_bank) begin
			prob_ok_q <= prob_ok;
			for (int k = 0; k < TOP_COUNT; k++) begin
				bank_score_q[k] <= nxt_score[k];
				bank_class_q[k] <= nxt_class[k];
			end
		end
	end

	// outputs
	assign rank_ext            = {{RW{1'b0}}, rd_q};
	assign out_valid           = out_valid_q;
	assign rank                = rank_ext[RW-1:0];
	assign class_index         = bank_class_q[rd_q];
	assign ranked_score        = bank_score_q[rd_q];
	assign probabilities_valid = prob_ok_q;
	assign last_of_run         = bank_last;

	// list order, for checking
	always_comb begin
		list_ordered = 1'b1;
		for (int k = 1; k < TOP_COUNT; k++) begin
			if (top_score_q[k-1] < top_score_q[k]) begin
				list_ordered = 1'b0;
			end
		end
	end

	// kept list never loses its descending order
	a_list_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		list_ordered)
		else $error("kept score list out of order");

	// a final item that leaves the input register starts a run at rank 0
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s1 && final_s1) |=> (out_valid && rd_q == '0))
		else $error("final item did not start a result run");

	// input only waits behind a final item while the bank is busy
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && final_s1 && out_valid_q))
		else $error("input stalled without a pending run");

endmodule

`default_nettype wire

// File: test/tb_top5_class_score_select_top.sv
// testbench for the top-five class score selector: directed runs and random runs
// keeps its own ranking of each score vector and checks every ranked result as it leaves
// depends on t5css_pkg and top5_class_score_select_top only
`default_nettype none

module tb_top5_class_score_select_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SCORE_W       = t5css_pkg::SCORE_W;
	localparam int CLASS_W       = t5css_pkg::CLASS_W;
	localparam int RANK_W        = t5css_pkg::RANK_W;
	localparam logic signed [SCORE_W-1:0] Q_ZERO = t5css_pkg::Q_ZERO;
	localparam logic signed [SCORE_W-1:0] Q_ONE  = t5css_pkg::Q_ONE;

	localparam int MAX_CLASSES   = t5css_pkg::MAX_CLASSES_DEF;
	localparam int TOP_COUNT     = t5css_pkg::TOP_COUNT_DEF;
	localparam int HALF_PERIOD   = 2;
	localparam int RESET_CYCLES  = 5;
	// a final item waits behind a draining bank; settle time after each drain
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int MAX_REPORTS   = 10;

	// boundary scores used by the random mix
	localparam logic signed [SCORE_W-1:0] EDGE_SCORES [5] =
		'{16'sh0000, 16'sh4000, 16'sh4001, 16'sh7fff, 16'sh8000};

	// one ranked result as it should leave the block
	typedef struct packed {
		logic [RANK_W-1:0]         rank;
		logic [CLASS_W-1:0]        class_index;
		logic signed [SCORE_W-1:0] ranked_score;
		logic                      probabilities_valid;
		logic                      last_of_run;
	} ranked_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// score channel, all inputs known from time zero
	logic                      in_valid    = 1'b0;
	logic                      in_stall;
	logic signed [SCORE_W-1:0] score       = '0;
	logic                      final_score = 1'b0;

	// ranked result channel
	logic                      out_valid;
	logic                      out_stall   = 1'b0;
	logic [RANK_W-1:0]         rank;
	logic [CLASS_W-1:0]        class_index;
	logic signed [SCORE_W-1:0] ranked_score;
	logic                      probabilities_valid;
	logic                      last_of_run;

	// own copy of the kept list and class counter
	logic signed [SCORE_W-1:0] kept_score [TOP_COUNT];
	logic [CLASS_W-1:0]        kept_class [TOP_COUNT];
	int                        class_count;

	// ranked results still to come, oldest first
	ranked_t ranked_q [$];

	// idling percentages for the sender and the receiver
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// run statistics
	int errors       = 0;
	int items_sent   = 0;
	int runs_sent    = 0;
	int results_seen = 0;
	int cycles       = 0;

	top5_class_score_select_top #(
		.MAX_CLASSES (MAX_CLASSES),
		.TOP_COUNT   (TOP_COUNT)
	) i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.score               (score),
		.final_score         (final_score),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.rank                (rank),
		.class_index         (class_index),
		.ranked_score        (ranked_score),
		.probabilities_valid (probabilities_valid),
		.last_of_run         (last_of_run)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// empty list and class counter back to zero
	function automatic void clear_list();
		for (int k = 0; k < TOP_COUNT; k++) begin
			kept_score[k] = Q_ZERO;
			kept_class[k] = '0;
		end
		class_count = 0;
	endfunction

	// rank one accepted score; a final item also queues the whole list, best first
	function automatic void rank_score(input logic signed [SCORE_W-1:0] s, input logic last);
		int      pos;
		logic    in_range;
		ranked_t r;
		// classes past the limit are dropped and the counter holds
		if (class_count < MAX_CLASSES) begin
			// first place whose kept score is strictly lower; ties stay below
			pos = TOP_COUNT;
			for (int k = TOP_COUNT - 1; k >= 0; k--)
				if (s > kept_score[k])
					pos = k;
			if (pos < TOP_COUNT) begin
				for (int k = TOP_COUNT - 1; k > pos; k--) begin
					kept_score[k] = kept_score[k-1];
					kept_class[k] = kept_class[k-1];
				end
				kept_score[pos] = s;
				kept_class[pos] = CLASS_W'(class_count);
			end
			class_count++;
		end
		if (last) begin
			// one flag for the whole run: every kept score within 0.0..1.0
			in_range = 1'b1;
			for (int k = 0; k < TOP_COUNT; k++)
				if (kept_score[k] < Q_ZERO || kept_score[k] > Q_ONE)
					in_range = 1'b0;
			for (int k = 0; k < TOP_COUNT; k++) begin
				r.rank                = RANK_W'(k);
				r.class_index         = kept_class[k];
				r.ranked_score        = kept_score[k];
				r.probabilities_valid = in_range;
				r.last_of_run         = (k == TOP_COUNT - 1);
				ranked_q = {ranked_q, r};
			end
			clear_list();
		end
	endfunction

	// random score: proper probabilities most often, plus ties, negatives, overshoots and edges
	function automatic logic signed [SCORE_W-1:0] pick_score(
			input logic signed [SCORE_W-1:0] prev);
		case ($urandom_range(9))
			0, 1, 2, 3: return SCORE_W'($urandom_range(16384));
			4:          return SCORE_W'($urandom);
			5:          return prev;
			6:          return SCORE_W'(-int'($urandom_range(1, 32768)));
			7:          return EDGE_SCORES[$urandom_range(4)];
			default:    return SCORE_W'($urandom_range(16385, 32767));
		endcase
	endfunction

	function automatic void report(input string what);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("[%0t] %s", $realtime, what);
	endfunction

	// offer one score item, idling at random first, and rank it once taken
	task automatic send_score(input logic signed [SCORE_W-1:0] s, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			// idle cycle with junk payload, which the block must ignore
			in_valid    <= 1'b0;
			score       <= SCORE_W'($urandom);
			final_score <= 1'($urandom);
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		score       <= s;
		final_score <= last;
		// taken at the first edge with stall low; the payload holds until then
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		rank_score(s, last);
		items_sent++;
		if (last)
			runs_sent++;
	endtask

	// stop offering and let every queued result leave, then a short settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (ranked_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// short hand-picked runs: empty list, ties, out-of-range scores, overfull list
	task automatic test_directed_cases();
		// lone zero final: unfilled list reports zeros of class 0
		send_score(Q_ZERO, 1'b1);
		// lone negative final never enters the list
		send_score(-16'sd1, 1'b1);
		// equal scores: the earlier class keeps the higher place
		send_score(Q_ONE, 1'b0);
		send_score(16'sh8000, 1'b0);
		send_score(Q_ONE, 1'b0);
		send_score(16'sd1, 1'b0);
		send_score(Q_ZERO, 1'b1);
		// largest score kept, so the probabilities flag drops
		send_score(16'sd100, 1'b0);
		send_score(16'sd200, 1'b0);
		send_score(16'sh7fff, 1'b1);
		// just above one on its own
		send_score(Q_ONE + 16'sd1, 1'b1);
		// seven rising scores: the two lowest fall off the end
		for (int i = 1; i <= 7; i++)
			send_score(SCORE_W'(i * 5), i == 7);
		wait_drained();
	endtask

	// random vectors, mostly short, now and then long enough to churn the list
	task automatic test_random_vectors(input int n_items);
		int                        sent;
		int                        len;
		logic signed [SCORE_W-1:0] s;
		sent = 0;
		s    = Q_ZERO;
		while (sent < n_items) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			for (int i = 0; i < len; i++) begin
				s = pick_score(s);
				send_score(s, i == len - 1);
			end
			sent += len;
		end
		wait_drained();
	endtask

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// result check: every taken result against the oldest expected one
	always @(posedge clk) begin : check_results
		ranked_t got;
		ranked_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			got = '{rank, class_index, ranked_score, probabilities_valid, last_of_run};
			if (ranked_q.size() == 0) begin
				report($sformatf("unexpected result rank %0d class %0d score %0d",
					rank, class_index, ranked_score));
			end else begin
				want = ranked_q.pop_front();
				if (got !== want)
					report($sformatf({"mismatch: exp rank %0d class %0d score %0d pv %0b last %0b",
						" / got rank %0d class %0d score %0d pv %0b last %0b"},
						want.rank, want.class_index, want.ranked_score,
						want.probabilities_valid, want.last_of_run,
						got.rank, got.class_index, got.ranked_score,
						got.probabilities_valid, got.last_of_run));
			end
		end
	end

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, ranked_q.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		clear_list();
		// reset held low at the start, released on a rising edge
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed runs with no idling on either side
		test_directed_cases();

		// random runs through the idling phases
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_random_vectors(85);
		send_idle_pct  = 78;
		recv_stall_pct = 0;
		test_random_vectors(85);
		send_idle_pct  = 0;
		recv_stall_pct = 78;
		test_random_vectors(85);
		send_idle_pct  = 31;
		recv_stall_pct = 31;
		test_random_vectors(85);

		$display("sent %0d score items in %0d vectors, checked %0d ranked results",
			items_sent, runs_sent, results_seen);
		$display("covered ties, unfilled lists, out-of-range scores and four idling phases");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches in total", errors);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
sv/t5css_pkg.sv
sv/top5_class_score_select_top.sv
test/tb_top5_class_score_select_top.sv
